[rtl/core/ihds_pkg.sv]
// Shared types, format codes and header constants for the image header dimension sniffer.
package ihds_pkg;

  localparam int POS_BITS_DEF = 32;

  typedef enum logic [1:0] {
    FMT_UNKNOWN  = 2'd0,
    FMT_PNG      = 2'd1,
    FMT_JPEG     = 2'd2,
    FMT_PNG_CAND = 2'd3
  } fmt_t;

  localparam logic [7:0] JPEG_SOI_0 = 8'hFF;
  localparam logic [7:0] JPEG_SOI_1 = 8'hD8;
  localparam logic [7:0] JPEG_SOF0  = 8'hC0;
  localparam logic [7:0] JPEG_SOF2  = 8'hC2;

  localparam int JPEG_FIRST_LEN = 4;
  localparam int PNG_SIG_LAST   = 7;
  localparam int PNG_W_FIRST    = 16;
  localparam int PNG_W_LAST     = 19;
  localparam int PNG_H_FIRST    = 20;
  localparam int PNG_H_LAST     = 23;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  image_format;
    logic [31:0] width;
    logic [31:0] height;
    logic        dims_found;
  } out_item_t;

  // PNG signature bytes 1..7, indexed from 0
  function automatic logic [7:0] png_sig(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h50;
      3'd1:    v = 8'h4E;
      3'd2:    v = 8'h47;
      3'd3:    v = 8'h0D;
      3'd4:    v = 8'h0A;
      3'd5:    v = 8'h1A;
      3'd6:    v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/ihds_parse.sv]
// Per-file parse state: format detection, PNG/JPEG header walk and result build.
module ihds_parse import ihds_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  localparam int PB = POSITION_BITS;
  localparam int EW = POSITION_BITS + 2;
  localparam logic [PB-1:0] POS_MAX   = '1;
  localparam logic [EW-1:0] POS_MAX_E = {2'b00, POS_MAX};

  logic [PB-1:0] pos_r,   pos_nxt;
  fmt_t          fmt_r,   fmt_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [PB-1:0] nlp_r,   nlp_nxt;
  logic [15:0]   seg_r,   seg_nxt;
  logic          sof_r,   sof_nxt;
  logic [31:0]   wacc_r,  wacc_nxt;
  logic [31:0]   hacc_r,  hacc_nxt;
  logic          sent_r,  sent_nxt;

  logic [EW-1:0] pos_e, base_e, seg_e, end_e;
  logic [15:0]   seg_v;
  logic [7:0]    b;
  logic          found, clear;

  function automatic logic [PB-1:0] sat_pos(input logic [EW-1:0] v);
    return (v > POS_MAX_E) ? POS_MAX : v[PB-1:0];
  endfunction

  assign b      = item.data_byte;
  assign pos_e  = {2'b00, pos_r};
  assign base_e = {2'b00, nlp_r};
  assign seg_e  = {{(EW-16){1'b0}}, seg_r};
  assign end_e  = base_e + seg_e + EW'(1);

  always_comb begin
    pos_nxt   = pos_r;
    fmt_nxt   = fmt_r;
    first_nxt = first_r;
    nlp_nxt   = nlp_r;
    seg_nxt   = seg_r;
    sof_nxt   = sof_r;
    wacc_nxt  = wacc_r;
    hacc_nxt  = hacc_r;
    sent_nxt  = sent_r;
    seg_v     = seg_r;
    found     = 1'b0;
    clear     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      if (sent_r) begin
        clear = item.last_byte;
      end else begin
        if (pos_r != POS_MAX) begin
          if (pos_r == '0) begin
            first_nxt = b;
          end else if (pos_r == PB'(1)) begin
            if (first_r == JPEG_SOI_0 && b == JPEG_SOI_1) begin
              fmt_nxt = FMT_JPEG;
            end else if (b == png_sig(3'd0)) begin
              fmt_nxt = FMT_PNG_CAND;
            end else begin
              fmt_nxt = FMT_UNKNOWN;
            end
          end else if (pos_r <= PB'(PNG_SIG_LAST) && fmt_r == FMT_PNG_CAND) begin
            if (b != png_sig(pos_r[2:0] - 3'd1)) begin
              fmt_nxt = FMT_UNKNOWN;
            end else if (pos_r == PB'(PNG_SIG_LAST)) begin
              fmt_nxt = FMT_PNG;
            end
          end

          if (fmt_nxt == FMT_PNG) begin
            if (pos_r >= PB'(PNG_W_FIRST) && pos_r <= PB'(PNG_W_LAST)) begin
              wacc_nxt = {wacc_r[23:0], b};
            end else if (pos_r >= PB'(PNG_H_FIRST) && pos_r <= PB'(PNG_H_LAST)) begin
              hacc_nxt = {hacc_r[23:0], b};
            end
            found = (pos_r == PB'(PNG_H_LAST));
          end else if (fmt_nxt == FMT_JPEG) begin
            if (sof_r) begin
              if (pos_e == base_e + EW'(5)) begin
                hacc_nxt = {16'h0000, b, 8'h00};
              end else if (pos_e == base_e + EW'(6)) begin
                hacc_nxt = hacc_r | {24'h000000, b};
              end else if (pos_e == base_e + EW'(7)) begin
                wacc_nxt = {16'h0000, b, 8'h00};
              end else if (pos_e == base_e + EW'(8)) begin
                wacc_nxt = wacc_r | {24'h000000, b};
                found    = 1'b1;
              end
            end else if (pos_e == base_e) begin
              seg_nxt = {b, 8'h00};
            end else if (pos_e == base_e + EW'(1)) begin
              seg_v   = {seg_r[15:8], b};
              seg_nxt = seg_v;
              if (seg_v == 16'h0000) begin
                nlp_nxt = sat_pos(base_e + EW'(2));
              end
            end else if (pos_e == end_e) begin
              if (b == JPEG_SOF0 || b == JPEG_SOF2) begin
                nlp_nxt = sat_pos(base_e + seg_e);
                sof_nxt = 1'b1;
              end else begin
                nlp_nxt = sat_pos(end_e + EW'(1));
              end
            end
          end
          pos_nxt = pos_r + PB'(1);
        end

        if (found) begin
          res_valid        = 1'b1;
          res.image_format = 2'(fmt_nxt);
          res.width        = wacc_nxt;
          res.height       = hacc_nxt;
          res.dims_found   = 1'b1;
          sent_nxt         = 1'b1;
        end else if (item.last_byte) begin
          res_valid        = 1'b1;
          res.image_format = (fmt_nxt == FMT_PNG_CAND) ? 2'(FMT_UNKNOWN) : 2'(fmt_nxt);
        end
        clear = item.last_byte;
      end
    end
    if (clear) begin
      pos_nxt   = '0;
      fmt_nxt   = FMT_UNKNOWN;
      first_nxt = 8'h00;
      nlp_nxt   = PB'(JPEG_FIRST_LEN);
      seg_nxt   = 16'h0000;
      sof_nxt   = 1'b0;
      wacc_nxt  = 32'h0;
      hacc_nxt  = 32'h0;
      sent_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fmt_r   <= FMT_UNKNOWN;
      first_r <= 8'h00;
      nlp_r   <= PB'(JPEG_FIRST_LEN);
      seg_r   <= 16'h0000;
      sof_r   <= 1'b0;
      wacc_r  <= 32'h0;
      hacc_r  <= 32'h0;
      sent_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      fmt_r   <= fmt_nxt;
      first_r <= first_nxt;
      nlp_r   <= nlp_nxt;
      seg_r   <= seg_nxt;
      sof_r   <= sof_nxt;
      wacc_r  <= wacc_nxt;
      hacc_r  <= hacc_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

[rtl/core/image_header_dimension_sniffer.sv]
// Top level: input register, parse stage and result register for the header sniffer.
// The parse state update is a single registered pass per byte taken from in_r.
// Throughput: one byte per cycle while out_stall holds no pending result.
// One result per file, on the byte that completes the dimensions or on the last byte.
// Reset (rst_n low, synchronous) empties both registers and clears the parse state.
// Position counters are POSITION_BITS wide and saturate.
module image_header_dimension_sniffer import ihds_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  in_item_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_r;
  logic      out_vld_r, out_vld_nxt;
  logic      go, in_xfer, res_valid;
  out_item_t res;

  assign go       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !go;
  assign in_xfer  = in_valid && !in_stall;

  ihds_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (go),
    .item      (in_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (go && res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
    if (go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[bench/tb_top.sv]
// Self-checking bench for image_header_dimension_sniffer: byte driver, result monitor, predictor.
module tb_top import ihds_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          BYTE_TARGET = 1250;
  localparam logic [63:0] POS_LIMIT   = (64'd1 << POS_BITS_DEF) - 64'd1;
  localparam logic [55:0] PNG_MAGIC   = 56'h504E470D0A1A0A;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  image_header_dimension_sniffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // sniffer state mirror
  logic [63:0] cur_pos;
  fmt_t        fmt_state;
  logic [7:0]  lead_byte;
  logic [63:0] len_at;
  logic [15:0] seg_len;
  logic        sof_seen;
  logic [31:0] w_acc;
  logic [31:0] h_acc;
  logic        dims_sent;

  in_item_t    pending_bytes[$];
  out_item_t   dims_expected[$];
  logic [7:0]  file_bytes[$];

  int          sniff_bytes  = 0;
  int          items_queued = 0;
  int          rx_checked   = 0;
  int          fails        = 0;
  int          files_sent   = 0;
  logic        in_took      = 1'b0;
  logic        out_took     = 1'b0;
  logic        in_quiet     = 1'b0;
  int          in_wait      = 0;
  int          rx_wait      = 0;
  int          rx_hold      = 0;
  int          rx_hold_mark = 8;

  function automatic logic [63:0] clamp_pos(input logic [63:0] v);
    return (v > POS_LIMIT) ? POS_LIMIT : v;
  endfunction

  task automatic clear_sniffer();
    cur_pos   = '0;
    fmt_state = FMT_UNKNOWN;
    lead_byte = '0;
    len_at    = 64'(JPEG_FIRST_LEN);
    seg_len   = '0;
    sof_seen  = 1'b0;
    w_acc     = '0;
    h_acc     = '0;
    dims_sent = 1'b0;
  endtask

  task automatic sniff_byte(input in_item_t it);
    logic [63:0] pos;
    logic [63:0] base;
    logic [7:0]  b;
    logic        hit;
    out_item_t   res;
    b   = it.data_byte;
    hit = 1'b0;
    if (dims_sent) begin
      if (it.last_byte) clear_sniffer();
      return;
    end
    sniff_bytes++;
    if (cur_pos < POS_LIMIT) begin
      pos = cur_pos;
      if (pos == 0) begin
        lead_byte = b;
      end else if (pos == 1) begin
        if (lead_byte == JPEG_SOI_0 && b == JPEG_SOI_1) fmt_state = FMT_JPEG;
        else if (b == PNG_MAGIC[48 +: 8]) fmt_state = FMT_PNG_CAND;
        else fmt_state = FMT_UNKNOWN;
      end else if (pos <= PNG_SIG_LAST && fmt_state == FMT_PNG_CAND) begin
        if (b != PNG_MAGIC[8 * (7 - pos[2:0]) +: 8]) fmt_state = FMT_UNKNOWN;
        else if (pos == PNG_SIG_LAST) fmt_state = FMT_PNG;
      end
      if (fmt_state == FMT_PNG) begin
        if (pos >= PNG_W_FIRST && pos <= PNG_W_LAST) w_acc = {w_acc[23:0], b};
        else if (pos >= PNG_H_FIRST && pos <= PNG_H_LAST) h_acc = {h_acc[23:0], b};
        if (pos == PNG_H_LAST) hit = 1'b1;
      end else if (fmt_state == FMT_JPEG) begin
        base = len_at;
        if (sof_seen) begin
          if (pos == base + 5) h_acc = {16'h0, b, 8'h00};
          else if (pos == base + 6) h_acc = h_acc | {24'h0, b};
          else if (pos == base + 7) w_acc = {16'h0, b, 8'h00};
          else if (pos == base + 8) begin
            w_acc = w_acc | {24'h0, b};
            hit   = 1'b1;
          end
        end else if (pos == base) begin
          seg_len = {b, 8'h00};
        end else if (pos == base + 1) begin
          seg_len = seg_len | {8'h00, b};
          if (seg_len == 0) len_at = clamp_pos(base + 2);
        end else if (pos == base + seg_len + 1) begin
          if (b == JPEG_SOF0 || b == JPEG_SOF2) begin
            len_at   = clamp_pos(base + seg_len);
            sof_seen = 1'b1;
          end else begin
            len_at = clamp_pos(base + seg_len + 2);
          end
        end
      end
      cur_pos = pos + 1;
    end
    if (hit) begin
      res.image_format = fmt_state;
      res.width        = w_acc;
      res.height       = h_acc;
      res.dims_found   = 1'b1;
      dims_expected.push_back(res);
      dims_sent = 1'b1;
    end else if (it.last_byte) begin
      res.image_format = (fmt_state == FMT_PNG_CAND) ? FMT_UNKNOWN : fmt_state;
      res.width        = '0;
      res.height       = '0;
      res.dims_found   = 1'b0;
      dims_expected.push_back(res);
    end
    if (it.last_byte) clear_sniffer();
  endtask

  // ---------------- file builders ----------------
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_dim(input logic [31:0] mask);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return mask;
    return $urandom & mask;
  endfunction

  task automatic add_tail();
    repeat ($urandom_range(0, 6)) file_bytes.push_back(rnd8());
  endtask

  task automatic add_png();
    logic [31:0] w;
    logic [31:0] h;
    w = pick_dim('1);
    h = pick_dim('1);
    file_bytes.push_back(($urandom_range(0, 3) == 0) ? rnd8() : 8'h89);
    for (int i = 1; i <= 7; i++) file_bytes.push_back(PNG_MAGIC[8 * (7 - i) +: 8]);
    repeat (8) file_bytes.push_back(rnd8());
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(h[8 * i +: 8]);
    add_tail();
  endtask

  task automatic add_jpeg();
    int          nseg;
    logic [15:0] slen;
    logic [15:0] dh;
    logic [15:0] dw;
    logic [7:0]  mk;
    file_bytes.push_back(JPEG_SOI_0);
    file_bytes.push_back(JPEG_SOI_1);
    file_bytes.push_back(rnd8());
    file_bytes.push_back(rnd8());
    nseg = $urandom_range(0, 3);
    for (int s = 0; s <= nseg; s++) begin
      slen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(25, 400))
                                           : 16'($urandom_range(0, 24));
      if (s == nseg && slen == 0) slen = 16'd1;
      file_bytes.push_back(slen[15:8]);
      file_bytes.push_back(slen[7:0]);
      if (slen != 0) begin
        repeat (slen - 1) file_bytes.push_back(rnd8());
        if (s == nseg) begin
          mk = $urandom_range(0, 1) ? JPEG_SOF0 : JPEG_SOF2;
        end else begin
          mk = rnd8();
          while (mk == JPEG_SOF0 || mk == JPEG_SOF2) mk = rnd8();
        end
        file_bytes.push_back(mk);
      end
    end
    dh = 16'(pick_dim(32'hFFFF));
    dw = 16'(pick_dim(32'hFFFF));
    repeat (3) file_bytes.push_back(rnd8());
    file_bytes.push_back(dh[15:8]);
    file_bytes.push_back(dh[7:0]);
    file_bytes.push_back(dw[15:8]);
    file_bytes.push_back(dw[7:0]);
    add_tail();
  endtask

  task automatic add_noise();
    int unsigned r;
    r = $urandom_range(0, 2);
    file_bytes.push_back(r == 0 ? JPEG_SOI_0 : (r == 1 ? 8'h89 : rnd8()));
    r = $urandom_range(0, 2);
    file_bytes.push_back(r == 0 ? JPEG_SOI_1 : (r == 1 ? PNG_MAGIC[48 +: 8] : rnd8()));
    repeat ($urandom_range(0, 22)) file_bytes.push_back(rnd8());
    if ($urandom_range(0, 3) == 0) begin
      while (file_bytes.size() > 1) void'(file_bytes.pop_back());
    end
  endtask

  task automatic damage_file();
    int n;
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
    end else begin
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = rnd8();
    end
  endtask

  task automatic commit_file();
    in_item_t it;
    for (int i = 0; i < file_bytes.size(); i++) begin
      it.data_byte = file_bytes[i];
      it.last_byte = (i == file_bytes.size() - 1);
      pending_bytes.push_back(it);
    end
    items_queued += file_bytes.size();
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (dims_expected.size() != 0) @(posedge clk);
  endtask

  // ---------------- driver ----------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (in_wait != 0) begin
      in_valid <= 1'b0;
      in_wait  <= in_wait - 1;
    end else if (pending_bytes.size() != 0) begin
      in_data  <= pending_bytes.pop_front();
      in_valid <= 1'b1;
      in_wait  <= in_quiet ? 0 : $urandom_range(0, 7);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------- receiver ----------------
  always @(negedge clk) begin : receiver
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if (rx_checked >= rx_hold_mark) begin
      out_stall    <= 1'b1;
      rx_hold      <= 400;
      rx_hold_mark <= rx_hold_mark + 30;
    end else if (out_took) begin
      n = rx_checked[4] ? 0 : $urandom_range(0, 7);
      out_stall <= (n != 0);
      rx_wait   <= (n != 0) ? n - 1 : 0;
    end else if (rx_wait != 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        rx_checked++;
        if (dims_expected.size() == 0) begin
          $error("unexpected result transfer: format %0d width %0d height %0d found %0b",
                 out_data.image_format, out_data.width, out_data.height,
                 out_data.dims_found);
          fails++;
        end else begin
          want = dims_expected.pop_front();
          if (out_data.image_format !== want.image_format) begin
            $error("image_format: expected %0d, got %0d", want.image_format,
                   out_data.image_format);
            fails++;
          end
          if (out_data.width !== want.width) begin
            $error("width: expected %0d, got %0d", want.width, out_data.width);
            fails++;
          end
          if (out_data.height !== want.height) begin
            $error("height: expected %0d, got %0d", want.height, out_data.height);
            fails++;
          end
          if (out_data.dims_found !== want.dims_found) begin
            $error("dims_found: expected %0b, got %0b", want.dims_found,
                   out_data.dims_found);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) sniff_byte(in_data);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[image_header_dimension_sniffer] ERROR");
    $finish;
  end

  // ---------------- stimulus ----------------
  initial begin : stimulus
    int unsigned r;
    clear_sniffer();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one-byte file, bare SOI, PNG signature cut short
    file_bytes.push_back(8'hFF);
    commit_file();
    file_bytes.push_back(JPEG_SOI_0);
    file_bytes.push_back(JPEG_SOI_1);
    commit_file();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(PNG_MAGIC[48 +: 8]);
    file_bytes.push_back(PNG_MAGIC[40 +: 8]);
    commit_file();
    // zero-length segment, then SOF2 with all-ones dimensions, then an ignored byte
    file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h01, JPEG_SOF2,
                  8'h08, 8'h00, 8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    commit_file();
    wait_idle();

    while (items_queued < BYTE_TARGET) begin
      if (pending_bytes.size() >= 32) begin
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r <= 3 || r == 8) add_jpeg();
        else if (r <= 6 || r == 9) add_png();
        else add_noise();
        if (r >= 8) damage_file();
        in_quiet = ($urandom_range(0, 3) == 0);
        commit_file();
        if (files_sent == 24) wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("sniffer run: %0d files, %0d bytes sent, %0d parsed, %0d results, %0d mismatches",
             files_sent, items_queued, sniff_bytes, rx_checked, fails);
    if (fails == 0) begin
      $display("[image_header_dimension_sniffer] OK");
    end else begin
      $display("[image_header_dimension_sniffer] ERROR");
    end
    $finish;
  end

endmodule
